// ===== design/rtnh_pkg.sv =====
// Shared types and constants for the ray/triangle nearest-hit block.
// No dependencies; used by the controller, the datapath and the top level.
package rtnh_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_ORIGIN    = 3'd0;
   localparam logic [2:0] CSR_DIRECTION = 3'd1;
   localparam logic [2:0] CSR_LOW       = 3'd2;
   localparam logic [2:0] CSR_HIGH      = 3'd3;
   localparam logic [2:0] CSR_KINDS     = 3'd4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 63;
   localparam int VEC_W      = 63;

   // Contact kind flags
   localparam logic [3:0] KIND_ENTER = 4'd1;
   localparam logic [3:0] KIND_EXIT  = 4'd2;
   localparam logic [3:0] KIND_HIT   = 4'd8;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   // Quotient bits produced by the plane-parameter divider
   localparam int DIV_STEPS = 33;

   // Datapath operation codes
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_LOAD     = 5'd1;
   localparam logic [4:0] OP_MUL_COS  = 5'd2;
   localparam logic [4:0] OP_MUL_OFF  = 5'd3;
   localparam logic [4:0] OP_SUM_OFF  = 5'd4;
   localparam logic [4:0] OP_DIV_INIT = 5'd5;
   localparam logic [4:0] OP_DIV_STEP = 5'd6;
   localparam logic [4:0] OP_DIV_DONE = 5'd7;
   localparam logic [4:0] OP_MUL_STEP = 5'd8;
   localparam logic [4:0] OP_POINT    = 5'd9;
   localparam logic [4:0] OP_MUL_UW   = 5'd10;
   localparam logic [4:0] OP_MUL_VW   = 5'd11;
   localparam logic [4:0] OP_SUM_VW   = 5'd12;
   localparam logic [4:0] OP_MUL_B1   = 5'd13;
   localparam logic [4:0] OP_MUL_B2   = 5'd14;
   localparam logic [4:0] OP_SUM_B2   = 5'd15;
   localparam logic [4:0] OP_MUL_INV  = 5'd16;
   localparam logic [4:0] OP_SUM_INV  = 5'd17;
   localparam logic [4:0] OP_UPDATE   = 5'd18;
   localparam logic [4:0] OP_EMIT     = 5'd19;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic cos_zero;
      logic in_range;
      logic last;
      logic rsp_full;
   } status_type;

endpackage

// ===== design/rtnh_channels.sv =====
// Handshake channel interfaces for triangle requests and hit responses.
// No dependencies.
interface rtnh_req_if;
   logic        valid;
   logic        ready;
   logic [62:0] corner;
   logic [62:0] edge_one;
   logic [62:0] edge_two;
   logic [62:0] unit_normal;
   logic [30:0] dot_one_one;
   logic signed [31:0] dot_one_two;
   logic [30:0] dot_two_two;
   logic signed [31:0] inverse_denominator;
   logic        last_face;

   modport source (output valid, corner, edge_one, edge_two, unit_normal, dot_one_one,
                   dot_one_two, dot_two_two, inverse_denominator, last_face,
                   input ready);
   modport sink (input valid, corner, edge_one, edge_two, unit_normal, dot_one_one,
                 dot_one_two, dot_two_two, inverse_denominator, last_face,
                 output ready);
endinterface

interface rtnh_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic signed [31:0] hit_distance;
   logic signed [31:0] bary_s;
   logic signed [31:0] bary_t;
   logic [62:0] hit_point;
   logic [62:0] hit_normal;
   logic [3:0]  contact_kind;

   modport source (output valid, found, hit_distance, bary_s, bary_t, hit_point,
                   hit_normal, contact_kind, input ready);
   modport sink (input valid, found, hit_distance, bary_s, bary_t, hit_point,
                 hit_normal, contact_kind, output ready);
endinterface

// ===== design/rtnh_ctrl.sv =====
// Sequencing state machine for the nearest-hit block.
// Depends on rtnh_pkg; drives datapath commands, reads datapath status.
module rtnh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rtnh_pkg::status_type status,
   output rtnh_pkg::cmd_type   cmd
);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_MUL_COS  = 5'd1;
   localparam logic [4:0] ST_MUL_OFF  = 5'd2;
   localparam logic [4:0] ST_SUM_OFF  = 5'd3;
   localparam logic [4:0] ST_DIV_INIT = 5'd4;
   localparam logic [4:0] ST_DIV_STEP = 5'd5;
   localparam logic [4:0] ST_DIV_DONE = 5'd6;
   localparam logic [4:0] ST_CHECK    = 5'd7;
   localparam logic [4:0] ST_MUL_STEP = 5'd8;
   localparam logic [4:0] ST_POINT    = 5'd9;
   localparam logic [4:0] ST_MUL_UW   = 5'd10;
   localparam logic [4:0] ST_MUL_VW   = 5'd11;
   localparam logic [4:0] ST_SUM_VW   = 5'd12;
   localparam logic [4:0] ST_MUL_B1   = 5'd13;
   localparam logic [4:0] ST_MUL_B2   = 5'd14;
   localparam logic [4:0] ST_SUM_B2   = 5'd15;
   localparam logic [4:0] ST_MUL_INV  = 5'd16;
   localparam logic [4:0] ST_SUM_INV  = 5'd17;
   localparam logic [4:0] ST_UPDATE   = 5'd18;
   localparam logic [4:0] ST_FINISH   = 5'd19;

   localparam int CNT_W = $clog2(rtnh_pkg::DIV_STEPS);

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state, step count and datapath command
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = rtnh_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = rtnh_pkg::OP_LOAD;
               state_in = ST_MUL_COS;
            end
         end
         ST_MUL_COS: begin
            cmd.op = rtnh_pkg::OP_MUL_COS;
            state_in = ST_MUL_OFF;
         end
         ST_MUL_OFF: begin
            cmd.op = rtnh_pkg::OP_MUL_OFF;
            state_in = ST_SUM_OFF;
         end
         ST_SUM_OFF: begin
            cmd.op = rtnh_pkg::OP_SUM_OFF;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op = rtnh_pkg::OP_DIV_INIT;
            cnt_in = '0;
            // a ray parallel to the plane never counts
            state_in = status.cos_zero ? ST_FINISH : ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.op = rtnh_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(rtnh_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            cmd.op = rtnh_pkg::OP_DIV_DONE;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.in_range ? ST_MUL_STEP : ST_FINISH;
         end
         ST_MUL_STEP: begin
            cmd.op = rtnh_pkg::OP_MUL_STEP;
            state_in = ST_POINT;
         end
         ST_POINT: begin
            cmd.op = rtnh_pkg::OP_POINT;
            state_in = ST_MUL_UW;
         end
         ST_MUL_UW: begin
            cmd.op = rtnh_pkg::OP_MUL_UW;
            state_in = ST_MUL_VW;
         end
         ST_MUL_VW: begin
            cmd.op = rtnh_pkg::OP_MUL_VW;
            state_in = ST_SUM_VW;
         end
         ST_SUM_VW: begin
            cmd.op = rtnh_pkg::OP_SUM_VW;
            state_in = ST_MUL_B1;
         end
         ST_MUL_B1: begin
            cmd.op = rtnh_pkg::OP_MUL_B1;
            state_in = ST_MUL_B2;
         end
         ST_MUL_B2: begin
            cmd.op = rtnh_pkg::OP_MUL_B2;
            state_in = ST_SUM_B2;
         end
         ST_SUM_B2: begin
            cmd.op = rtnh_pkg::OP_SUM_B2;
            state_in = ST_MUL_INV;
         end
         ST_MUL_INV: begin
            cmd.op = rtnh_pkg::OP_MUL_INV;
            state_in = ST_SUM_INV;
         end
         ST_SUM_INV: begin
            cmd.op = rtnh_pkg::OP_SUM_INV;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op = rtnh_pkg::OP_UPDATE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // last face waits for room in the response register
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (!status.rsp_full) begin
               cmd.op   = rtnh_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/rtnh_datapath.sv =====
// Datapath: config registers, three multiplier lanes, restoring divider,
// nearest-hit state and response register. Depends on rtnh_pkg.
module rtnh_datapath #(
   parameter int COORD_BITS = 21
) (
   input  logic                clock,
   input  logic                reset,
   input  rtnh_pkg::cmd_type   cmd,
   output rtnh_pkg::status_type status,
   // configuration writes
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [62:0]         csr_wdata,
   // request payload
   input  logic [62:0]         corner,
   input  logic [62:0]         edge_one,
   input  logic [62:0]         edge_two,
   input  logic [62:0]         unit_normal,
   input  logic [30:0]         dot_one_one,
   input  logic signed [31:0]  dot_one_two,
   input  logic [30:0]         dot_two_two,
   input  logic signed [31:0]  inverse_denominator,
   input  logic                last_face,
   // response register
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                found,
   output logic signed [31:0]  hit_distance,
   output logic signed [31:0]  bary_s,
   output logic signed [31:0]  bary_t,
   output logic [62:0]         hit_point,
   output logic [62:0]         hit_normal,
   output logic [3:0]          contact_kind
);

   localparam int C   = COORD_BITS;
   localparam int CW  = 2 * C + 2;              // cosine
   localparam int OW  = 2 * C + 3;              // offset
   localparam int DW  = 2 * C + 2;              // divisor magnitude
   localparam int RW  = DW + 1;                 // partial remainder
   localparam int WW  = C + 16;                 // hit point and w
   localparam int AW  = 33;
   localparam int BW  = (WW > 32) ? WW : 32;
   localparam int PW  = AW + BW;
   localparam int SW  = PW + 2;
   localparam int QW  = rtnh_pkg::DIV_STEPS;
   localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MIN32 = 32'sh80000000;
   localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

   function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
      logic signed [31:0] r;
      if (x > SW'(MAX32)) r = MAX32;
      else if (x < SW'(MIN32)) r = MIN32;
      else r = 32'(x);
      return r;
   endfunction

   function automatic logic signed [C-1:0] satc(input logic signed [WW-1:0] x);
      logic signed [C-1:0] r;
      if (x > WW'(CMAX)) r = CMAX;
      else if (x < WW'(CMIN)) r = CMIN;
      else r = C'(x);
      return r;
   endfunction

   // Config registers
   logic [62:0]        org_ff, dir_ff;
   logic signed [31:0] low_ff, high_ff;
   logic [2:0]         kinds_ff;

   // Item registers
   logic [62:0]        corner_ff, e1_ff, e2_ff, nrm_ff;
   logic [30:0]        d11_ff, d22_ff;
   logic signed [31:0] d12_ff, inv_ff;
   logic               last_ff;

   // Working registers
   logic signed [PW-1:0] prod_ff [3];
   logic signed [PW-1:0] prod_in [3];
   logic signed [CW-1:0] cos_ff, cos_in;
   logic signed [OW-1:0] off_ff, off_in;
   logic [DW-1:0]        den_ff, den_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        nsh_ff, nsh_in, q_ff, q_in;
   logic                 ovf_ff, ovf_in, neg_ff, neg_in;
   logic [3:0]           kind_ff, kind_in;
   logic signed [31:0]   t_ff, t_in;
   logic signed [WW-1:0] p_ff [3];
   logic signed [WW-1:0] p_in [3];
   logic signed [WW-1:0] w_ff [3];
   logic signed [WW-1:0] w_in [3];
   logic signed [31:0]   uw_ff, uw_in, vw_ff, vw_in;
   logic signed [31:0]   sn_ff, sn_in, tn_ff, tn_in;
   logic signed [31:0]   s_ff, s_in, tt_ff, tt_in;

   // Query state
   logic signed [31:0]   far_ff, far_in;
   logic                 have_ff, have_in;
   logic signed [31:0]   bdist_ff, bdist_in, bs_ff, bs_in, bt_ff, bt_in;
   logic [62:0]          bpoint_ff, bpoint_in, bnorm_ff, bnorm_in;
   logic [3:0]           bkind_ff, bkind_in;

   // Response register
   logic                 rv_ff, rv_in;
   logic                 rfound_ff;
   logic signed [31:0]   rdist_ff, rs_ff, rt_ff;
   logic [62:0]          rpoint_ff, rnorm_ff;
   logic [3:0]           rkind_ff;

   // Unpacked components
   logic signed [C-1:0]  o_c [3];
   logic signed [C-1:0]  d_c [3];
   logic signed [C-1:0]  v0_c [3];
   logic signed [C-1:0]  u_c [3];
   logic signed [C-1:0]  v_c [3];
   logic signed [C-1:0]  n_c [3];
   logic signed [AW-1:0] opa [3];
   logic signed [BW-1:0] opb [3];

   logic signed [SW-1:0] sum3, diff01;
   logic [OW-1:0]        abs_off;
   logic [DW-1:0]        abs_cos;
   logic [RW-1:0]        trial;
   logic [QW-1:0]        qc;
   logic signed [31:0]   t_calc;
   logic signed [32:0]   st_sum;
   logic                 hit;
   logic [62:0]          point_pack, norm_pack;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_c[i]  = org_ff[i*C +: C];
         d_c[i]  = dir_ff[i*C +: C];
         v0_c[i] = corner_ff[i*C +: C];
         u_c[i]  = e1_ff[i*C +: C];
         v_c[i]  = e2_ff[i*C +: C];
         n_c[i]  = nrm_ff[i*C +: C];
      end
   end

   // Lane operand selection
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[i] = '0;
         opb[i] = '0;
      end
      case (cmd.op)
         rtnh_pkg::OP_MUL_COS: begin
            for (int i = 0; i < 3; i++) begin
               opa[i] = AW'(n_c[i]);
               opb[i] = BW'(d_c[i]);
            end
         end
         rtnh_pkg::OP_MUL_OFF: begin
            for (int i = 0; i < 3; i++) begin
               opa[i] = AW'(n_c[i]);
               opb[i] = BW'((C+1)'(o_c[i]) - (C+1)'(v0_c[i]));
            end
         end
         rtnh_pkg::OP_MUL_STEP: begin
            for (int i = 0; i < 3; i++) begin
               opa[i] = AW'(d_c[i]);
               opb[i] = BW'(t_ff);
            end
         end
         rtnh_pkg::OP_MUL_UW: begin
            for (int i = 0; i < 3; i++) begin
               opa[i] = AW'(u_c[i]);
               opb[i] = BW'(w_ff[i]);
            end
         end
         rtnh_pkg::OP_MUL_VW: begin
            for (int i = 0; i < 3; i++) begin
               opa[i] = AW'(v_c[i]);
               opb[i] = BW'(w_ff[i]);
            end
         end
         rtnh_pkg::OP_MUL_B1: begin
            opa[0] = AW'(signed'({1'b0, d22_ff}));
            opb[0] = BW'(uw_ff);
            opa[1] = AW'(d12_ff);
            opb[1] = BW'(vw_ff);
         end
         rtnh_pkg::OP_MUL_B2: begin
            opa[0] = AW'(signed'({1'b0, d11_ff}));
            opb[0] = BW'(vw_ff);
            opa[1] = AW'(d12_ff);
            opb[1] = BW'(uw_ff);
         end
         rtnh_pkg::OP_MUL_INV: begin
            opa[0] = AW'(sn_ff);
            opb[0] = BW'(inv_ff);
            opa[1] = AW'(tn_ff);
            opb[1] = BW'(inv_ff);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PW'(opa[i]) * PW'(opb[i]);
      end
   end

   // Shared helpers on the registered products, offset, cosine and divider state
   assign sum3    = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
   assign diff01  = SW'(prod_ff[0]) - SW'(prod_ff[1]);
   assign abs_off = off_ff[OW-1] ? OW'(-off_ff) : OW'(off_ff);
   assign abs_cos = cos_ff[CW-1] ? DW'(-cos_ff) : DW'(cos_ff);
   assign trial   = {rem_ff[RW-2:0], nsh_ff[QW-1]};

   // Quotient clamp and sign
   always_comb begin
      if (ovf_ff || (q_ff > QW'(33'h080000000))) begin
         qc = QW'(33'h080000000);
      end else begin
         qc = q_ff;
      end
      if (neg_ff) begin
         t_calc = 32'(-qc);
      end else if (qc[31]) begin
         t_calc = MAX32;
      end else begin
         t_calc = 32'(qc);
      end
   end

   assign st_sum = 33'(s_ff) + 33'(tt_ff);
   assign hit = (s_ff >= 0) && (s_ff <= rtnh_pkg::ONE_Q16) &&
                (tt_ff >= 0) && (tt_ff <= rtnh_pkg::ONE_Q16) &&
                (st_sum >= 0) && (st_sum <= 33'(rtnh_pkg::ONE_Q16));

   always_comb begin
      point_pack = '0;
      norm_pack  = '0;
      for (int i = 0; i < 3; i++) begin
         point_pack[i*C +: C] = satc(p_ff[i]);
         norm_pack[i*C +: C]  = n_c[i];
      end
   end

   // Next-state logic of the working registers
   always_comb begin
      cos_in = cos_ff;
      off_in = off_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      nsh_in = nsh_ff;
      q_in   = q_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      kind_in = kind_ff;
      t_in   = t_ff;
      uw_in  = uw_ff;
      vw_in  = vw_ff;
      sn_in  = sn_ff;
      tn_in  = tn_ff;
      s_in   = s_ff;
      tt_in  = tt_ff;
      for (int i = 0; i < 3; i++) begin
         p_in[i] = p_ff[i];
         w_in[i] = w_ff[i];
      end
      case (cmd.op)
         rtnh_pkg::OP_MUL_OFF: begin
            cos_in = CW'(sum3);
         end
         rtnh_pkg::OP_SUM_OFF: begin
            off_in = OW'(sum3);
         end
         rtnh_pkg::OP_DIV_INIT: begin
            den_in  = abs_cos;
            ovf_in  = ((OW+18)'(abs_off) >= ((OW+18)'(abs_cos) << 17));
            rem_in  = RW'(abs_off >> 17);
            nsh_in  = {abs_off[16:0], 16'b0};
            q_in    = '0;
            neg_in  = (off_ff > 0) != (cos_ff < 0);
            kind_in = (cos_ff < 0) ? rtnh_pkg::KIND_ENTER : rtnh_pkg::KIND_EXIT;
         end
         rtnh_pkg::OP_DIV_STEP: begin
            nsh_in = {nsh_ff[QW-2:0], 1'b0};
            if (trial >= RW'(den_ff)) begin
               rem_in = trial - RW'(den_ff);
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
         end
         rtnh_pkg::OP_DIV_DONE: begin
            t_in = t_calc;
         end
         rtnh_pkg::OP_POINT: begin
            // p = o + round(d*t / 2^16), w = p - corner
            for (int i = 0; i < 3; i++) begin
               p_in[i] = WW'(o_c[i]) +
                         WW'((SW'(prod_ff[i]) + SW'(32'sd32768)) >>> 16);
               w_in[i] = p_in[i] - WW'(v0_c[i]);
            end
         end
         rtnh_pkg::OP_MUL_VW: begin
            uw_in = sat32((sum3 + SW'(8)) >>> 4);
         end
         rtnh_pkg::OP_SUM_VW: begin
            vw_in = sat32((sum3 + SW'(8)) >>> 4);
         end
         rtnh_pkg::OP_MUL_B2: begin
            sn_in = sat32((diff01 + SW'(32'sd32768)) >>> 16);
         end
         rtnh_pkg::OP_SUM_B2: begin
            tn_in = sat32((diff01 + SW'(32'sd32768)) >>> 16);
         end
         rtnh_pkg::OP_SUM_INV: begin
            s_in  = sat32((SW'(prod_ff[0]) + SW'(32'sd8388608)) >>> 24);
            tt_in = sat32((SW'(prod_ff[1]) + SW'(32'sd8388608)) >>> 24);
         end
         default: begin
         end
      endcase
   end

   // Query state and response register next values
   always_comb begin
      far_in    = far_ff;
      have_in   = have_ff;
      bdist_in  = bdist_ff;
      bs_in     = bs_ff;
      bt_in     = bt_ff;
      bpoint_in = bpoint_ff;
      bnorm_in  = bnorm_ff;
      bkind_in  = bkind_ff;
      rv_in     = rv_ff && !rsp_ready;
      if (csr_we) begin
         // a known register index restarts the query
         case (csr_index)
            rtnh_pkg::CSR_ORIGIN, rtnh_pkg::CSR_DIRECTION, rtnh_pkg::CSR_LOW,
            rtnh_pkg::CSR_HIGH, rtnh_pkg::CSR_KINDS: begin
               far_in    = (csr_index == rtnh_pkg::CSR_HIGH) ? csr_wdata[31:0] : high_ff;
               have_in   = 1'b0;
               bdist_in  = '0;
               bs_in     = '0;
               bt_in     = '0;
               bpoint_in = '0;
               bnorm_in  = '0;
               bkind_in  = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.op == rtnh_pkg::OP_UPDATE && hit) begin
         far_in    = t_ff;
         have_in   = 1'b1;
         bdist_in  = t_ff;
         bs_in     = s_ff;
         bt_in     = tt_ff;
         bpoint_in = point_pack;
         bnorm_in  = norm_pack;
         bkind_in  = kind_ff | rtnh_pkg::KIND_HIT;
      end else if (cmd.op == rtnh_pkg::OP_EMIT) begin
         rv_in     = 1'b1;
         far_in    = high_ff;
         have_in   = 1'b0;
         bdist_in  = '0;
         bs_in     = '0;
         bt_in     = '0;
         bpoint_in = '0;
         bnorm_in  = '0;
         bkind_in  = '0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff    <= '0;
         dir_ff    <= '0;
         low_ff    <= '0;
         high_ff   <= MAX32;
         kinds_ff  <= 3'd3;
         far_ff    <= MAX32;
         have_ff   <= 1'b0;
         bdist_ff  <= '0;
         bs_ff     <= '0;
         bt_ff     <= '0;
         bpoint_ff <= '0;
         bnorm_ff  <= '0;
         bkind_ff  <= '0;
         rv_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rtnh_pkg::CSR_ORIGIN:    org_ff   <= csr_wdata;
               rtnh_pkg::CSR_DIRECTION: dir_ff   <= csr_wdata;
               rtnh_pkg::CSR_LOW:       low_ff   <= csr_wdata[31:0];
               rtnh_pkg::CSR_HIGH:      high_ff  <= csr_wdata[31:0];
               rtnh_pkg::CSR_KINDS:     kinds_ff <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
         far_ff    <= far_in;
         have_ff   <= have_in;
         bdist_ff  <= bdist_in;
         bs_ff     <= bs_in;
         bt_ff     <= bt_in;
         bpoint_ff <= bpoint_in;
         bnorm_ff  <= bnorm_in;
         bkind_ff  <= bkind_in;
         rv_ff     <= rv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == rtnh_pkg::OP_LOAD) begin
         corner_ff <= corner;
         e1_ff     <= edge_one;
         e2_ff     <= edge_two;
         nrm_ff    <= unit_normal;
         d11_ff    <= dot_one_one;
         d12_ff    <= dot_one_two;
         d22_ff    <= dot_two_two;
         inv_ff    <= inverse_denominator;
         last_ff   <= last_face;
      end
      if (cmd.op == rtnh_pkg::OP_EMIT) begin
         rfound_ff <= have_ff;
         rdist_ff  <= bdist_ff;
         rs_ff     <= bs_ff;
         rt_ff     <= bt_ff;
         rpoint_ff <= bpoint_ff;
         rnorm_ff  <= bnorm_ff;
         rkind_ff  <= bkind_ff;
      end
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
         p_ff[i]    <= p_in[i];
         w_ff[i]    <= w_in[i];
      end
      cos_ff  <= cos_in;
      off_ff  <= off_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      nsh_ff  <= nsh_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
      kind_ff <= kind_in;
      t_ff    <= t_in;
      uw_ff   <= uw_in;
      vw_ff   <= vw_in;
      sn_ff   <= sn_in;
      tn_ff   <= tn_in;
      s_ff    <= s_in;
      tt_ff   <= tt_in;
   end

   // Status to the controller
   assign status.cos_zero = (cos_ff == '0);
   assign status.in_range = (t_ff >= low_ff) && (t_ff <= far_ff) &&
                            ((kinds_ff & kind_ff[2:0]) != 3'd0);
   assign status.last     = last_ff;
   assign status.rsp_full = rv_ff && !rsp_ready;

   assign rsp_valid    = rv_ff;
   assign found        = rfound_ff;
   assign hit_distance = rdist_ff;
   assign bary_s       = rs_ff;
   assign bary_t       = rt_ff;
   assign hit_point    = rpoint_ff;
   assign hit_normal   = rnorm_ff;
   assign contact_kind = rkind_ff;

`ifndef SYNTHESIS
   // kept hit always sits at the current far end
   a_far_tracks_best: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (bdist_ff == far_ff))
      else $error("kept hit distance differs from interval end");

   // kept hit carries the hit flag, empty query carries none
   a_kind_flag: assert property (@(posedge clock) disable iff (reset)
      have_ff == bkind_ff[3])
      else $error("hit flag out of step with kept hit");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rtnh_pkg::OP_DIV_STEP && !ovf_ff) |-> (rem_ff < RW'(den_ff)))
      else $error("divider remainder out of range");

   // emitting restarts the query
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rtnh_pkg::OP_EMIT && !csr_we) |=> (!have_ff && rv_ff))
      else $error("query not restarted after response");
`endif

endmodule

// ===== design/ray_triangle_nearest_hit_top.sv =====
// Top level of the ray/triangle nearest-hit block.
// Depends on rtnh_pkg, rtnh_channels, rtnh_ctrl and rtnh_datapath.
//
// One ray is written through the csr_ port; triangles then stream in on
// req_chan, one at a time, and the face marked last_face yields one result
// on rsp_chan (nearest hit or not found) and restarts the query. A triangle
// is done early when the ray is parallel to its plane, or when the plane
// parameter from the 33-step restoring divider is outside the interval or
// its contact kind is not enabled; else the full barycentric test runs on
// the shared three-lane multiplier. The response sits in its own register,
// so the next triangle is taken while a result waits.
module ray_triangle_nearest_hit_top #(
   parameter int COORD_BITS = 21
) (
   input  logic            clock,
   input  logic            reset,
   rtnh_req_if.sink        req_chan,
   rtnh_rsp_if.source      rsp_chan,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [62:0]     csr_wdata
);

   rtnh_pkg::cmd_type    cmd;
   rtnh_pkg::status_type status;

   // Sequencer
   rtnh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state
   rtnh_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .corner              (req_chan.corner),
      .edge_one            (req_chan.edge_one),
      .edge_two            (req_chan.edge_two),
      .unit_normal         (req_chan.unit_normal),
      .dot_one_one         (req_chan.dot_one_one),
      .dot_one_two         (req_chan.dot_one_two),
      .dot_two_two         (req_chan.dot_two_two),
      .inverse_denominator (req_chan.inverse_denominator),
      .last_face           (req_chan.last_face),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .found               (rsp_chan.found),
      .hit_distance        (rsp_chan.hit_distance),
      .bary_s              (rsp_chan.bary_s),
      .bary_t              (rsp_chan.bary_t),
      .hit_point           (rsp_chan.hit_point),
      .hit_normal          (rsp_chan.hit_normal),
      .contact_kind        (rsp_chan.contact_kind)
   );

endmodule
